[hdl/lyp_pkg.sv]
// Shared types, constants and tables for the look-at yaw/pitch block.
package lyp_pkg;

  localparam int DIFF_W      = 33;
  localparam int CORD_W      = 40;
  localparam int ANG_W       = 32;
  localparam int YAW_W       = 15;
  localparam int PITCH_W     = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int NORM_POS    = 29;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic [ANG_W-1:0] YAW_LIMIT   = 32'd12868;
  localparam logic [ANG_W-1:0] PITCH_LIMIT = 32'd6434;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 2'd3;

  // Queue entry: direction plus its classification
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic                     near_cand;
    logic [1:0]               rsh;
    logic [4:0]               lsh;
  } lyp_entry_t;

  // One CORDIC vector state
  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } lyp_cord_t;

  // atan(2^-i) in Q.24 radians, rounded to nearest
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      5'd24: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // Rotate a left-half-plane vector by +-pi/2 before vectoring
  function automatic lyp_cord_t prerot(input logic signed [CORD_W-1:0] x,
                                       input logic signed [CORD_W-1:0] y);
    lyp_cord_t c;
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = HALF_PI_Q24;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -HALF_PI_Q24;
      end
    end
    return c;
  endfunction

  // Round Q.24 to Q3.12 half away from zero, then saturate
  function automatic logic signed [ANG_W-1:0] to_q12(input logic signed [ANG_W-1:0] a,
                                                    input logic [ANG_W-1:0] limit);
    logic [ANG_W-1:0] mag;
    logic [ANG_W-1:0] r;
    mag = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
    r = (mag + 32'd2048) >> 12;
    if (r > limit) r = limit;
    return a[ANG_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

[hdl/lyp_front.sv]
// Front end: forms the direction, classifies it and pushes it to the queue.
module lyp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_target_x,
  input  logic signed [31:0]            in_target_y,
  input  logic signed [31:0]            in_target_z,
  input  logic signed [31:0]            camera_x,
  input  logic signed [31:0]            camera_y,
  input  logic signed [31:0]            camera_z,
  input  logic [15:0]                   epsilon,
  output logic                          push,
  output lyp_pkg::lyp_entry_t           push_entry,
  input  logic                          q_full
);
  import lyp_pkg::*;

  logic                     a_valid_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r, a_dz_r;
  logic [DIFF_W-1:0]        ax, ay, az, m;
  logic [5:0]               pos;

  assign in_stall = a_valid_r && q_full;
  assign push     = a_valid_r && !q_full;

  // Register the direction and hold it until it is pushed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid_r <= 1'b1;
    end else if (push) begin
      a_valid_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      a_dx_r <= DIFF_W'(in_target_x) - DIFF_W'(camera_x);
      a_dy_r <= DIFF_W'(in_target_y) - DIFF_W'(camera_y);
      a_dz_r <= DIFF_W'(in_target_z) - DIFF_W'(camera_z);
    end
  end

  // Classify: near box test and normalizing shift from the leading one
  always_comb begin
    ax = a_dx_r[DIFF_W-1] ? DIFF_W'(-a_dx_r) : DIFF_W'(a_dx_r);
    ay = a_dy_r[DIFF_W-1] ? DIFF_W'(-a_dy_r) : DIFF_W'(a_dy_r);
    az = a_dz_r[DIFF_W-1] ? DIFF_W'(-a_dz_r) : DIFF_W'(a_dz_r);
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    pos = '0;
    for (int k = 0; k < DIFF_W; k++) begin
      if (m[k]) pos = 6'(k);
    end
    push_entry.dx        = a_dx_r;
    push_entry.dy        = a_dy_r;
    push_entry.dz        = a_dz_r;
    push_entry.near_cand = (ax <= DIFF_W'(epsilon)) && (ay <= DIFF_W'(epsilon)) &&
                           (az <= DIFF_W'(epsilon));
    push_entry.rsh   = (pos > 6'(NORM_POS)) ? 2'(pos - 6'(NORM_POS)) : 2'd0;
    push_entry.lsh   = (pos < 6'(NORM_POS)) ? 5'(6'(NORM_POS) - pos) : 5'd0;
  end

endmodule

[hdl/lyp_queue.sv]
// Two-entry queue between the front end and the back end.
module lyp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lyp_pkg::lyp_entry_t push_entry,
  input  logic                pop,
  output lyp_pkg::lyp_entry_t head,
  output logic                empty,
  output logic                full
);
  import lyp_pkg::*;

  lyp_entry_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

[hdl/lyp_back.sv]
// Back end: squares, square roots, CORDIC atan2 and the result register.
module lyp_back #(
  parameter int CORDIC_ITERATIONS  = 16,
  parameter int POSITION_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lyp_pkg::lyp_entry_t head,
  input  logic                q_empty,
  output logic                pop,
  input  logic [15:0]         epsilon,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [14:0]  out_yaw,
  output logic signed [13:0]  out_pitch,
  output logic                out_updated
);
  import lyp_pkg::*;

  localparam int N      = (CORDIC_ITERATIONS > 30) ? 30 : CORDIC_ITERATIONS;
  localparam int ITER_W = $clog2(N);

  typedef enum logic [2:0] {
    S_IDLE, S_NEAR, S_NCHK, S_SQ, S_SQRT, S_CHK, S_CORD, S_OUT
  } state_t;

  state_t              st_r;
  logic [1:0]          step_r;
  logic [3:0]          sq_cnt_r;
  logic [ITER_W-1:0]   it_r;
  logic signed [31:0]  sx_r, sy_r, sz_r;
  logic [15:0]         ax_r, ay_r, az_r;
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod_r;
  logic [63:0]         acc_r;
  logic [63:0]         v1_r, r1_r, v2_r, r2_r, bit_r;
  logic [63:0]         v1_n, r1_n, v2_n, r2_n;
  lyp_cord_t           pc_r, yc_r, pc_n, yc_n;
  logic                upd_r, yaw_ok_r;
  logic signed [YAW_W-1:0]   cur_yaw_r;
  logic signed [PITCH_W-1:0] cur_pitch_r;
  logic signed [YAW_W-1:0]   res_yaw;
  logic signed [PITCH_W-1:0] res_pitch;
  logic                out_valid_r;
  logic signed [YAW_W-1:0]   out_yaw_r;
  logic signed [PITCH_W-1:0] out_pitch_r;
  logic                out_upd_r;
  logic signed [DIFF_W-1:0]  nx, ny, nz;
  logic [DIFF_W-1:0]   hax, hay, haz;
  logic                slot_free;

  assign pop         = (st_r == S_IDLE) && !q_empty;
  assign slot_free   = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_yaw     = out_yaw_r;
  assign out_pitch   = out_pitch_r;
  assign out_updated = out_upd_r;

  // One restoring square-root step
  function automatic logic [127:0] isq_step(input logic [63:0] v, input logic [63:0] r,
                                            input logic [63:0] b);
    logic [63:0] t;
    t = r + b;
    if (v >= t) return {v - t, (r >> 1) + b};
    return {v, r >> 1};
  endfunction

  // One CORDIC vectoring step
  function automatic lyp_cord_t cstep(input lyp_cord_t c, input logic [ITER_W-1:0] i);
    lyp_cord_t o;
    logic signed [ANG_W-1:0] a;
    a = $signed({8'd0, atan_q24(5'(i))});
    if (c.y > 0) begin
      o.x = c.x + (c.y >>> i);
      o.y = c.y - (c.x >>> i);
      o.z = c.z + a;
    end else begin
      o.x = c.x - (c.y >>> i);
      o.y = c.y + (c.x >>> i);
      o.z = c.z - a;
    end
    return o;
  endfunction

  // Normalize the head entry; magnitudes for the near test
  always_comb begin
    if (head.rsh != 2'd0) begin
      nx = head.dx >>> head.rsh;
      ny = head.dy >>> head.rsh;
      nz = head.dz >>> head.rsh;
    end else begin
      nx = head.dx <<< head.lsh;
      ny = head.dy <<< head.lsh;
      nz = head.dz <<< head.lsh;
    end
    hax = head.dx[DIFF_W-1] ? DIFF_W'(-head.dx) : DIFF_W'(head.dx);
    hay = head.dy[DIFF_W-1] ? DIFF_W'(-head.dy) : DIFF_W'(head.dy);
    haz = head.dz[DIFF_W-1] ? DIFF_W'(-head.dz) : DIFF_W'(head.dz);
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == S_NEAR) begin
      case (step_r)
        2'd0:    mul_a = $signed({16'd0, ax_r});
        2'd1:    mul_a = $signed({16'd0, ay_r});
        2'd2:    mul_a = $signed({16'd0, az_r});
        default: mul_a = $signed({16'd0, epsilon});
      endcase
      mul_b = mul_a;
    end else if (st_r == S_SQ) begin
      case (step_r)
        2'd0:    mul_a = sx_r;
        2'd1:    mul_a = sz_r;
        default: mul_a = sy_r;
      endcase
      mul_b = mul_a;
    end else if (st_r == S_CHK) begin
      mul_a = $signed({16'd0, epsilon});
      mul_b = $signed(r2_r[31:0]);
    end
  end

  // Two square-root steps per cycle for both roots; CORDIC steps
  always_comb begin
    {v1_n, r1_n} = isq_step(v1_r, r1_r, bit_r);
    {v1_n, r1_n} = isq_step(v1_n, r1_n, bit_r >> 2);
    {v2_n, r2_n} = isq_step(v2_r, r2_r, bit_r);
    {v2_n, r2_n} = isq_step(v2_n, r2_n, bit_r >> 2);
    pc_n = cstep(pc_r, it_r);
    yc_n = cstep(yc_r, it_r);
    res_pitch = PITCH_W'(to_q12(pc_r.z, PITCH_LIMIT));
    res_yaw   = YAW_W'(to_q12(yc_r.z, YAW_LIMIT));
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_yaw_r   <= '0;
      cur_pitch_r <= '0;
    end else begin
      if (out_valid_r && !out_stall && (st_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            sx_r   <= 32'(nx);
            sy_r   <= 32'(ny);
            sz_r   <= 32'(nz);
            ax_r   <= hax[15:0];
            ay_r   <= hay[15:0];
            az_r   <= haz[15:0];
            step_r <= 2'd0;
            st_r   <= head.near_cand ? S_NEAR : S_SQ;
          end
        end
        S_NEAR: begin
          step_r <= step_r + 2'd1;
          acc_r  <= (step_r == 2'd1) ? 64'(prod_r) : acc_r + 64'(prod_r);
          if (step_r == 2'd3) st_r <= S_NCHK;
        end
        S_NCHK: begin
          step_r <= 2'd0;
          if (acc_r <= 64'(prod_r)) begin
            upd_r <= 1'b0;
            st_r  <= S_OUT;
          end else begin
            st_r  <= S_SQ;
          end
        end
        S_SQ: begin
          step_r <= step_r + 2'd1;
          acc_r  <= (step_r == 2'd1) ? 64'(prod_r) : acc_r + 64'(prod_r);
          if (step_r == 2'd3) begin
            v1_r     <= acc_r;
            v2_r     <= acc_r + 64'(prod_r);
            r1_r     <= '0;
            r2_r     <= '0;
            bit_r    <= 64'd1 << 62;
            sq_cnt_r <= '0;
            st_r     <= S_SQRT;
          end
        end
        S_SQRT: begin
          v1_r     <= v1_n;
          r1_r     <= r1_n;
          v2_r     <= v2_n;
          r2_r     <= r2_n;
          bit_r    <= bit_r >> 4;
          sq_cnt_r <= sq_cnt_r + 4'd1;
          if (sq_cnt_r == 4'd15) st_r <= S_CHK;
        end
        S_CHK: begin
          pc_r <= prerot(CORD_W'(r1_r[31:0]), CORD_W'(sy_r));
          yc_r <= prerot(CORD_W'(sx_r), -CORD_W'(sz_r));
          it_r <= '0;
          st_r <= S_CORD;
        end
        S_CORD: begin
          if (it_r == '0) yaw_ok_r <= ((64'(r1_r[31:0]) << POSITION_FRAC_BITS) >
                                       64'(prod_r));
          pc_r <= pc_n;
          yc_r <= yc_n;
          it_r <= it_r + 1'b1;
          if (it_r == ITER_W'(N - 1)) begin
            upd_r <= 1'b1;
            st_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_upd_r   <= upd_r;
            if (upd_r) begin
              cur_pitch_r <= res_pitch;
              out_pitch_r <= res_pitch;
              if (yaw_ok_r) begin
                cur_yaw_r <= res_yaw;
                out_yaw_r <= res_yaw;
              end else begin
                out_yaw_r <= cur_yaw_r;
              end
            end else begin
              out_yaw_r   <= cur_yaw_r;
              out_pitch_r <= cur_pitch_r;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/look_at_yaw_pitch.sv]
// Top level of the look-at yaw/pitch block.
//
//  channel  ports                                       direction
//  in       in_valid/in_stall, in_target_x/y/z          target position in
//  out      out_valid/out_stall, out_yaw/pitch/updated  angles out
//  cfg      cfg_we, cfg_index, cfg_wdata                camera position, epsilon
//
// An item passes from acceptance to a valid result through the front register,
// the queue, the multiplies, the two-bits-per-cycle square-root unit, a setup
// state, one CORDIC step per cycle (iterations capped at 30) and the output state.
// A near target skips the square roots and CORDIC; one inside the epsilon box but
// outside the epsilon length goes on through the full path.
// Reset is synchronous and active low; it clears the stored angles.
// A stalled result holds in the output register; the front end and the
// two-entry queue keep taking items until the queue fills.
module look_at_yaw_pitch #(
  parameter int CORDIC_ITERATIONS  = 16,
  parameter int POSITION_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_target_x,
  input  logic signed [31:0]              in_target_y,
  input  logic signed [31:0]              in_target_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [14:0]              out_yaw,
  output logic signed [13:0]              out_pitch,
  output logic                            out_updated,
  input  logic                            cfg_we,
  input  logic [lyp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata
);
  import lyp_pkg::*;

  logic signed [31:0] camera_x_r, camera_y_r, camera_z_r;
  logic [15:0]        epsilon_r;
  logic               push, pop, q_empty, q_full;
  lyp_entry_t         push_entry, head;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_x_r <= '0;
      camera_y_r <= '0;
      camera_z_r <= '0;
      epsilon_r  <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAMERA_X: camera_x_r <= cfg_wdata;
        REG_CAMERA_Y: camera_y_r <= cfg_wdata;
        REG_CAMERA_Z: camera_z_r <= cfg_wdata;
        REG_EPSILON:  epsilon_r  <= cfg_wdata[15:0];
        default:      ;
      endcase
    end
  end

  lyp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_target_x, .in_target_y, .in_target_z,
    .camera_x(camera_x_r), .camera_y(camera_y_r), .camera_z(camera_z_r),
    .epsilon(epsilon_r), .push, .push_entry, .q_full
  );

  lyp_queue u_queue (
    .clk, .rst_n, .push, .push_entry, .pop, .head, .empty(q_empty), .full(q_full)
  );

  lyp_back #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
    .POSITION_FRAC_BITS(POSITION_FRAC_BITS)
  ) u_back (
    .clk, .rst_n, .head, .q_empty, .pop, .epsilon(epsilon_r),
    .out_valid, .out_stall, .out_yaw, .out_pitch, .out_updated
  );

endmodule

[hdl/lyp_checker.sv]
// Port-level checks for the look-at yaw/pitch block, bound to the top level.
module lyp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [14:0] out_yaw,
  input logic signed [13:0] out_pitch
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_yaw) && $stable(out_pitch))
    else $error("stalled result changed");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Yaw stays within +-pi
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw >= -15'sd12868) && (out_yaw <= 15'sd12868))
    else $error("yaw out of range");

  // Pitch stays within +-pi/2
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch >= -14'sd6434) && (out_pitch <= 14'sd6434))
    else $error("pitch out of range");

endmodule

bind look_at_yaw_pitch lyp_checker u_lyp_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_yaw, .out_pitch
);
